/* src/pfra_pkg.sv */
// Package for the page frame run allocator: shared types and constants.
// No dependencies.
package pfra_pkg;

  localparam int unsigned FRAMES_DEF = 4096;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned TAG_W      = 8;
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned FREE_W     = 13;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NO_RUN    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REJECT = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [COUNT_W-1:0] count;
    logic [TAG_W-1:0]   tag;
    logic [INDEX_W-1:0] first;
  } cmd_t;

endpackage

/* src/pfra_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pfra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* src/pfra_front.sv */
// Front end: takes transactions, classifies them, holds them in a 2-entry queue.
// Depends on pfra_pkg.
module pfra_front import pfra_pkg::*; #(
  parameter int unsigned FRAMES = FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               mode_i,
  input  logic [COUNT_W-1:0] frame_count_i,
  input  logic [TAG_W-1:0]   owner_tag_i,
  input  logic [INDEX_W-1:0] first_frame_i,
  input  logic               clear_busy_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  localparam int unsigned QDEPTH = 2;

  cmd_t       q_mem_q [QDEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push_ok, pop_ok;
  cmd_t       cls;

  // Reject bad requests here so the back end only sees work or a report
  always_comb begin
    cls.count = frame_count_i;
    cls.tag   = owner_tag_i;
    cls.first = first_frame_i;
    if (!mode_i) begin
      cls.op = (frame_count_i == '0 || owner_tag_i == '0) ? OP_REJECT : OP_ALLOC;
    end else begin
      cls.op = (frame_count_i == '0 || 32'(first_frame_i) >= 32'(FRAMES)) ?
               OP_REJECT : OP_FREE;
    end
  end

  assign full_o      = (cnt_q == 2'(QDEPTH)) || clear_busy_i;
  assign push_ok     = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop_ok      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) wr_ptr_q <= ~wr_ptr_q;
      if (pop_ok)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

/* src/pfra_back.sv */
// Back end: tag table sequencer (clear, scan, fill, sweep) and result register.
// Depends on pfra_pkg and pfra_ram.
module pfra_back import pfra_pkg::*; #(
  parameter int unsigned FRAMES = FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [INDEX_W-1:0] search_start_i,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               clear_busy_o,
  output logic               res_valid_o,
  input  logic               res_pop_i,
  output status_e            status_o,
  output logic [INDEX_W-1:0] run_start_o,
  output logic [FREE_W-1:0]  frames_free_o
);

  localparam int unsigned IDX_W = $clog2(FRAMES);
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned WW    = (CNT_W > 14) ? CNT_W : 14;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_FILL, S_SWEEP, S_REPORT
  } state_e;

  state_e             state_q, state_d;
  logic               res_valid_q, res_valid_d;
  logic               pend_q, pend_d;
  logic [CNT_W-1:0]   free_q, free_d;
  logic [IDX_W-1:0]   wr_addr_q, wr_addr_d;

  logic [CNT_W-1:0]   rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]   end_q, end_d;
  logic [IDX_W-1:0]   pend_addr_q, pend_addr_d;
  logic [CNT_W-1:0]   run_len_q, run_len_d;
  logic [IDX_W-1:0]   run_start_q, run_start_d;
  logic [CNT_W-1:0]   need_q, need_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  status_e            rep_status_q, rep_status_d;
  logic [IDX_W-1:0]   rep_start_q, rep_start_d;
  status_e            res_status_q, res_status_d;
  logic [IDX_W-1:0]   res_start_q, res_start_d;
  logic [CNT_W-1:0]   res_free_q, res_free_d;

  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [TAG_W-1:0]   wr_data, rd_data;
  logic [31:0]        free_end;
  logic [WW-1:0]      start_w, free_w;

  pfra_ram #(
    .WIDTH (TAG_W),
    .DEPTH (FRAMES)
  ) u_tags (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  // Free range end, clipped at the table end
  assign free_end = (32'(cmd_i.first) + 32'(cmd_i.count) > 32'(FRAMES)) ?
                    32'(FRAMES) : 32'(cmd_i.first) + 32'(cmd_i.count);

  always_comb begin
    state_d      = state_q;
    res_valid_d  = res_valid_q;
    pend_d       = pend_q;
    free_d       = free_q;
    wr_addr_d    = wr_addr_q;
    rd_addr_d    = rd_addr_q;
    end_d        = end_q;
    pend_addr_d  = pend_addr_q;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    need_d       = need_q;
    tag_d        = tag_q;
    rep_status_d = rep_status_q;
    rep_start_d  = rep_start_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_free_d   = res_free_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = wr_addr_q;
    wr_data      = '0;
    cmd_pop_o    = 1'b0;

    if (res_pop_i && res_valid_q) res_valid_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr_d = wr_addr_q + IDX_W'(1);
        if (wr_addr_q == IDX_W'(FRAMES - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        pend_d      = 1'b0;
        rep_start_d = '0;
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_ALLOC: begin
              if (32'(free_q) < 32'(cmd_i.count)) begin
                rep_status_d = ST_EXHAUSTED;
                state_d      = S_REPORT;
              end else if (32'(search_start_i) >= 32'(FRAMES)) begin
                rep_status_d = ST_NO_RUN;
                state_d      = S_REPORT;
              end else begin
                rd_addr_d = CNT_W'(search_start_i);
                end_d     = CNT_W'(FRAMES);
                need_d    = CNT_W'(cmd_i.count);
                tag_d     = cmd_i.tag;
                run_len_d = '0;
                state_d   = S_SCAN;
              end
            end
            OP_FREE: begin
              rd_addr_d = CNT_W'(cmd_i.first);
              end_d     = CNT_W'(free_end);
              state_d   = S_SWEEP;
            end
            OP_REJECT: begin
              rep_status_d = ST_INVALID;
              state_d      = S_REPORT;
            end
            default: begin
              rep_status_d = ST_INVALID;
              state_d      = S_REPORT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Reads run one frame ahead of the run tracker
        if (rd_addr_q != end_q) begin
          rd_en       = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = rd_addr_q[IDX_W-1:0];
          rd_addr_d   = rd_addr_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (rd_data == '0) begin
            if (run_len_q == '0) run_start_d = pend_addr_q;
            run_len_d = run_len_q + CNT_W'(1);
            if (run_len_q + CNT_W'(1) == need_q) begin
              wr_addr_d = (run_len_q == '0) ? pend_addr_q : run_start_q;
              pend_d    = 1'b0;
              state_d   = S_FILL;
            end
          end else begin
            run_len_d = '0;
          end
        end else if (rd_addr_q == end_q) begin
          rep_status_d = ST_NO_RUN;
          state_d      = S_REPORT;
        end
      end

      S_FILL: begin
        wr_en     = 1'b1;
        wr_data   = tag_q;
        wr_addr_d = wr_addr_q + IDX_W'(1);
        need_d    = need_q - CNT_W'(1);
        free_d    = free_q - CNT_W'(1);
        if (need_q == CNT_W'(1)) begin
          rep_status_d = ST_OK;
          rep_start_d  = run_start_q;
          state_d      = S_REPORT;
        end
      end

      S_SWEEP: begin
        if (rd_addr_q != end_q) begin
          rd_en       = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = rd_addr_q[IDX_W-1:0];
          rd_addr_d   = rd_addr_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          // Only frames in use are cleared and counted back
          if (rd_data != '0) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_q;
            free_d  = free_q + CNT_W'(1);
          end
        end else if (rd_addr_q == end_q) begin
          rep_status_d = ST_OK;
          state_d      = S_REPORT;
        end
      end

      S_REPORT: begin
        if (!res_valid_q || res_pop_i) begin
          res_valid_d  = 1'b1;
          res_status_d = rep_status_q;
          res_start_d  = rep_start_q;
          res_free_d   = free_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      res_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      free_q      <= CNT_W'(FRAMES);
      wr_addr_q   <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      pend_q      <= pend_d;
      free_q      <= free_d;
      wr_addr_q   <= wr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q    <= rd_addr_d;
    end_q        <= end_d;
    pend_addr_q  <= pend_addr_d;
    run_len_q    <= run_len_d;
    run_start_q  <= run_start_d;
    need_q       <= need_d;
    tag_q        <= tag_d;
    rep_status_q <= rep_status_d;
    rep_start_q  <= rep_start_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_free_q   <= res_free_d;
  end

  assign start_w       = WW'(res_start_q);
  assign free_w        = WW'(res_free_q);
  assign clear_busy_o  = (state_q == S_CLEAR);
  assign res_valid_o   = res_valid_q;
  assign status_o      = res_status_q;
  assign run_start_o   = start_w[INDEX_W-1:0];
  assign frames_free_o = free_w[FREE_W-1:0];

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CNT_W'(FRAMES))
    else $error("free count above table size");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !res_valid_q)
    else $error("result during clearing pass");

  a_fail_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_status_q != ST_OK |-> res_start_q == '0)
    else $error("failed transaction reports a run start");

  a_port_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && rd_en |-> wr_addr != rd_addr_q[IDX_W-1:0])
    else $error("read and write of the same frame in one cycle");

endmodule

/* src/page_frame_run_allocator_unit.sv */
// Top level of the first-fit page frame run allocator.
// Depends on pfra_pkg, pfra_front, pfra_back (and pfra_ram below it).
// Flow: a reject or an allocate with too few free frames goes straight to the report;
//   a free sweeps its clipped range; an allocate scans from the search start, then fills
//   the run, or reports no run when the scan reaches the table end.
// Throughput: one transaction at a time through the tag table, one frame per cycle.
// Reset: async, active low; then a clearing pass zeroes every entry of the tag RAM,
//   full is held high during it. Config writes are taken at any time.
module page_frame_run_allocator_unit import pfra_pkg::*; #(
  parameter int unsigned FRAMES = FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: search start frame
  input  logic               cfg_we_i,
  input  logic [INDEX_W-1:0] cfg_wdata_i,
  // request queue side
  input  logic               push,
  output logic               full,
  input  logic               mode_i,
  input  logic [COUNT_W-1:0] frame_count_i,
  input  logic [TAG_W-1:0]   owner_tag_i,
  input  logic [INDEX_W-1:0] first_frame_i,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status_o,
  output logic [INDEX_W-1:0] run_start_o,
  output logic [FREE_W-1:0]  frames_free_o
);

  logic [INDEX_W-1:0] search_start_q;
  logic               cmd_valid, cmd_pop, clear_busy, res_valid;
  cmd_t               cmd;
  status_e            status;

  // Search start register; sampled by the back end when an allocate starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_start_q <= '0;
    end else if (cfg_we_i) begin
      search_start_q <= cfg_wdata_i;
    end
  end

  // Front: validation and a two-deep transaction queue
  pfra_front #(
    .FRAMES (FRAMES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .mode_i        (mode_i),
    .frame_count_i (frame_count_i),
    .owner_tag_i   (owner_tag_i),
    .first_frame_i (first_frame_i),
    .clear_busy_i  (clear_busy),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // Back: tag table walks and the result register
  pfra_back #(
    .FRAMES (FRAMES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .search_start_i (search_start_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .clear_busy_o   (clear_busy),
    .res_valid_o    (res_valid),
    .res_pop_i      (pop),
    .status_o       (status),
    .run_start_o    (run_start_o),
    .frames_free_o  (frames_free_o)
  );

  assign empty    = !res_valid;
  assign status_o = status;

endmodule
